// ----- hdl/cgm_pkg.sv -----
package cgm_pkg;

  localparam int MAX_LEN_DEF = 64;

  localparam logic [1:0] CMD_PAT  = 2'd0;
  localparam logic [1:0] CMD_TXT  = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  localparam logic [7:0] CH_ANY  = 8'h3F;
  localparam logic [7:0] CH_STAR = 8'h2A;

  localparam int IN_W  = 16;
  localparam int OUT_W = 8;

  typedef struct packed {
    logic append_pat;
    logic append_txt;
    logic init;
    logic step;
    logic finish;
    logic match;
  } cgm_cmd_t;

  typedef struct packed {
    logic ovf;
    logic plen_zero;
    logic s_lt;
    logic p_lt;
    logic step_fail;
    logic out_free;
  } cgm_status_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- hdl/cgm_ctrl.sv -----
module cgm_ctrl
  import cgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  cgm_status_t status,
  output cgm_cmd_t    cmd
);

  typedef enum logic [4:0] {
    IDLE  = 5'b00001,
    CHECK = 5'b00010,
    READ  = 5'b00100,
    STEP  = 5'b01000,
    FIN   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   match_q, match_q_next;
  logic   accept;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    match_q_next = match_q;
    cmd          = '0;
    cmd.match    = match_q;
    unique case (state)
      IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_PAT:  cmd.append_pat = 1'b1;
            CMD_TXT:  cmd.append_txt = 1'b1;
            CMD_EVAL: begin
              cmd.init   = 1'b1;
              state_next = CHECK;
            end
            default: ;
          endcase
        end
      end
      CHECK: begin
        if (status.ovf || status.plen_zero) begin
          match_q_next = 1'b0;
          state_next   = FIN;
        end else if (status.s_lt || status.p_lt) begin
          state_next = READ;
        end else begin
          match_q_next = 1'b1;
          state_next   = FIN;
        end
      end
      READ: state_next = STEP;
      STEP: begin
        cmd.step = 1'b1;
        if (status.step_fail) begin
          match_q_next = 1'b0;
          state_next   = FIN;
        end else begin
          state_next = CHECK;
        end
      end
      FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      match_q <= 1'b0;
    end else begin
      state   <= state_next;
      match_q <= match_q_next;
    end
  end

  // a tail step only ever looks at a pattern byte that exists
  assert property (@(posedge clk) disable iff (rst)
    (state == STEP && !status.s_lt) |-> status.p_lt)
    else $error("tail step past end of pattern");

  assert property (@(posedge clk) disable iff (rst)
    (state == READ) |=> (state == STEP))
    else $error("read not followed by step");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == IDLE))
    else $error("finish did not return to idle");

endmodule

// ----- hdl/cgm_datapath.sv -----
module cgm_datapath
  import cgm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  byte_in,
  input  cgm_cmd_t    cmd,
  output cgm_status_t status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_matched,
  output logic        out_overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LW-1:0] FULL = LW'(MAX_LEN);
  localparam logic [LW-1:0] ONE  = LW'(1);

  logic [7:0]    pat_mem [MAX_LEN];
  logic [7:0]    txt_mem [MAX_LEN];
  logic [7:0]    pat_q, txt_q;
  logic [LW-1:0] plen, slen, p, s, star_pos, resume;
  logic          have_star, ovf;
  logic [7:0]    pc, sc;
  logic          p_lt, s_lt;

  assign p_lt = (p < plen);
  assign s_lt = (s < slen);
  assign pc   = fold_byte(pat_q);
  assign sc   = fold_byte(txt_q);

  always_comb begin
    status           = '0;
    status.ovf       = ovf;
    status.plen_zero = (plen == '0);
    status.s_lt      = s_lt;
    status.p_lt      = p_lt;
    status.out_free  = !out_valid || out_ready;
    if (s_lt) begin
      status.step_fail = !(p_lt && (pc == CH_ANY || pc == sc)) &&
                         !(p_lt && pc == CH_STAR) && !have_star;
    end else begin
      status.step_fail = (pc != CH_STAR);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append_pat && plen < FULL) begin
      pat_mem[plen[AW-1:0]] <= byte_in;
    end
    if (cmd.append_txt && slen < FULL) begin
      txt_mem[slen[AW-1:0]] <= byte_in;
    end
    pat_q <= pat_mem[p[AW-1:0]];
    txt_q <= txt_mem[s[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen      <= '0;
      slen      <= '0;
      ovf       <= 1'b0;
      p         <= '0;
      s         <= '0;
      have_star <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.append_pat) begin
        if (plen < FULL) plen <= plen + ONE;
        else ovf <= 1'b1;
      end
      if (cmd.append_txt) begin
        if (slen < FULL) slen <= slen + ONE;
        else ovf <= 1'b1;
      end
      if (cmd.init) begin
        p         <= '0;
        s         <= '0;
        have_star <= 1'b0;
      end
      if (cmd.step && !status.step_fail) begin
        if (s_lt) begin
          if (p_lt && (pc == CH_ANY || pc == sc)) begin
            p <= p + ONE;
            s <= s + ONE;
          end else if (p_lt && pc == CH_STAR) begin
            star_pos  <= p;
            have_star <= 1'b1;
            p         <= p + ONE;
            resume    <= s;
          end else begin
            // backtrack: let the last star swallow one more byte
            p      <= star_pos + ONE;
            resume <= resume + ONE;
            s      <= resume + ONE;
          end
        end else begin
          p <= p + ONE;
        end
      end
      if (cmd.finish) begin
        out_valid    <= 1'b1;
        out_matched  <= cmd.match;
        out_overflow <= ovf;
        plen         <= '0;
        slen         <= '0;
        ovf          <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (plen == '0 && slen == '0 && !ovf && out_valid))
    else $error("stores not emptied after evaluate");

  assert property (@(posedge clk) disable iff (rst)
    (have_star && !cmd.init) |-> (resume <= s && star_pos < p))
    else $error("backtrack point ahead of match position");

  assert property (@(posedge clk) disable iff (rst)
    (plen <= FULL && slen <= FULL))
    else $error("store length beyond capacity");

endmodule

// ----- hdl/caseless_glob_matcher.sv -----
// caseless glob matcher
// input channel s_axis: one beat per command. cmd 0 appends byte_in to the
// pattern store, cmd 1 appends it to the text store, cmd 2 evaluates and
// empties both stores, cmd 3 does nothing. each store holds MAX_LEN bytes;
// further bytes are dropped and raise the overflow flag.
// output channel m_axis: one beat per evaluate, carrying matched and overflow.
// append beats give no result and leave s_axis_tready high. an evaluate
// checks the indices, then for every match step (compare, star, backtrack
// or trailing star) reads a byte pair, takes the step and checks again, then
// loads the result register; the step count is up to about MAX_LEN squared,
// set by the single backtracking walk over the two stores.
// s_axis_tready is low while an evaluate is running.
// a result waiting on a stalled receiver holds in the output register;
// appends are still taken, and a following evaluate runs but holds its
// result until the earlier beat is taken.
// reset clears lengths, overflow flag and the output valid; store contents
// need no clearing.
module caseless_glob_matcher
  import cgm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // cmd[1:0], byte_in[9:2], zeros
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // matched[0], overflow[1], zeros
);

  cgm_cmd_t    cmd;
  cgm_status_t status;
  logic        matched, overflow;

  cgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tdata[1:0]),
    .status   (status),
    .cmd      (cmd)
  );

  cgm_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (s_axis_tdata[9:2]),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_matched  (matched),
    .out_overflow (overflow)
  );

  assign m_axis_tdata = {{(OUT_W-2){1'b0}}, overflow, matched};

endmodule

// ----- tb/sv/glob_verdict_checker.sv -----
module glob_verdict_checker
  import cgm_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // cmd[1:0], byte_in[9:2], zeros
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,   // matched[0], overflow[1], zeros
  output int               fail_count,
  output int               pending,
  output int               eval_count,
  output int               match_count,
  output int               ovf_count
);

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic [7:0] pat_mem [MAX_LEN];
  logic [7:0] txt_mem [MAX_LEN];
  int         pat_len = 0;
  int         txt_len = 0;
  logic       ovf_seen = 1'b0;
  verdict_t   verdicts_due [$];
  int         fails = 0;
  int         outstanding = 0;
  int         evals = 0;
  int         hits = 0;
  int         ovfs = 0;

  assign fail_count  = fails;
  assign pending     = outstanding;
  assign eval_count  = evals;
  assign match_count = hits;
  assign ovf_count   = ovfs;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // greedy walk, backtracking only to the most recent star
  function automatic logic pattern_covers_text();
    int         p;
    int         s;
    int         star_at;
    int         resume;
    logic       seen_star;
    logic [7:0] pc;
    logic [7:0] tc;
    p = 0;
    s = 0;
    star_at = 0;
    resume = 0;
    seen_star = 1'b0;
    if (pat_len == 0) return 1'b0;
    while (s < txt_len) begin
      tc = to_lower(txt_mem[s]);
      pc = (p < pat_len) ? to_lower(pat_mem[p]) : 8'h00;
      if (p < pat_len && (pc == CH_ANY || pc == tc)) begin
        p++;
        s++;
      end else if (p < pat_len && pc == CH_STAR) begin
        star_at = p;
        seen_star = 1'b1;
        p++;
        resume = s;
      end else if (seen_star) begin
        p = star_at + 1;
        resume++;
        s = resume;
      end else begin
        return 1'b0;
      end
    end
    while (p < pat_len && to_lower(pat_mem[p]) == CH_STAR) p++;
    return p == pat_len;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t   want;
    verdict_t   got;
    logic [1:0] op;
    logic [7:0] b;
    if (rst) begin
      pat_len = 0;
      txt_len = 0;
      ovf_seen = 1'b0;
      verdicts_due.delete();
      outstanding = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.matched  = m_axis_tdata[0];
        got.overflow = m_axis_tdata[1];
        if (verdicts_due.size() == 0) begin
          $error("result beat with no evaluate waiting: matched %0b overflow %0b",
                 got.matched, got.overflow);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          outstanding--;
          if (got.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, got.matched);
            fails++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op = s_axis_tdata[1:0];
        b  = s_axis_tdata[9:2];
        case (op)
          CMD_PAT: begin
            if (pat_len < MAX_LEN) begin
              pat_mem[pat_len] = b;
              pat_len++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          CMD_TXT: begin
            if (txt_len < MAX_LEN) begin
              txt_mem[txt_len] = b;
              txt_len++;
            end else begin
              ovf_seen = 1'b1;
            end
          end
          CMD_EVAL: begin
            want.overflow = ovf_seen;
            want.matched  = ovf_seen ? 1'b0 : pattern_covers_text();
            verdicts_due = {verdicts_due, want};
            outstanding++;
            evals++;
            if (want.matched) hits++;
            if (want.overflow) ovfs++;
            pat_len = 0;
            txt_len = 0;
            ovf_seen = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import cgm_pkg::*;

  localparam logic [1:0] CMD_NOP       = 2'd3;
  localparam int         ITEM_TARGET   = 1950;
  localparam int         CYCLE_LIMIT   = 2_000_000;
  localparam int         SETTLE_CYCLES = 3 * MAX_LEN_DEF * MAX_LEN_DEF + 400;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;    // cmd[1:0], byte_in[9:2], zeros
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;         // matched[0], overflow[1], zeros

  int fail_count;
  int pending;
  int eval_count;
  int match_count;
  int ovf_count;

  int cycles = 0;
  int beats_sent = 0;
  int burst_left = 0;
  int rx_mode = 0;

  logic [7:0] pat_q [$];
  logic [7:0] txt_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  caseless_glob_matcher #(.MAX_LEN(MAX_LEN_DEF)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  glob_verdict_checker #(.MAX_LEN(MAX_LEN_DEF)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .eval_count    (eval_count),
    .match_count   (match_count),
    .ovf_count     (ovf_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stall pattern, picking one of four styles at random and switching it periodically
  always @(negedge clk) begin
    if (cycles % 700 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (cycles % 7) > 2;
    endcase
  end

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    case ($urandom_range(0, 15))
      0: c = CH_STAR;
      1: c = CH_ANY;
      2: c = 8'h40;
      3: c = 8'h5B;
      4: c = 8'h60;
      5: c = 8'h7B;
      default: begin
        c = 8'h61 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) c = c - 8'h20;
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pattern_char();
    case ($urandom_range(0, 9))
      0, 1: return CH_STAR;
      2: return CH_ANY;
      default: return text_char();
    endcase
  endfunction

  function automatic void pat_add(input logic [7:0] c);
    pat_q = {pat_q, c};
  endfunction

  function automatic void txt_add(input logic [7:0] c);
    txt_q = {txt_q, c};
  endfunction

  function automatic void set_case(input string p, input string t);
    pat_q.delete();
    txt_q.delete();
    for (int i = 0; i < p.len(); i++) pat_add(p[i]);
    for (int i = 0; i < t.len(); i++) txt_add(t[i]);
  endfunction

  // entered and left at a falling edge; valid stays up between back-to-back beats
  task automatic push_beat(input logic [1:0] op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W-10){1'b0}}, b, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    if (op != CMD_NOP) beats_sent++;
  endtask

  // pattern and text bytes interleaved at random, with an occasional nop beat, then the evaluate
  task automatic emit_case();
    int pi;
    int ti;
    pi = 0;
    ti = 0;
    while (pi < pat_q.size() || ti < txt_q.size()) begin
      if ($urandom_range(0, 19) == 0) push_beat(CMD_NOP, 8'($urandom_range(0, 255)));
      if (ti >= txt_q.size() || (pi < pat_q.size() && $urandom_range(0, 1))) begin
        push_beat(CMD_PAT, pat_q[pi]);
        pi++;
      end else begin
        push_beat(CMD_TXT, txt_q[ti]);
        ti++;
      end
    end
    push_beat(CMD_EVAL, 8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    int         kind;
    int         n;
    logic [7:0] c;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_case("", "");
    emit_case();
    set_case("", "a");
    emit_case();
    set_case("**", "");
    emit_case();
    set_case("*?C", "abxc");
    emit_case();
    // star meeting a star in the text is taken literally first
    set_case("*b", "*ab");
    push_beat(CMD_NOP, 8'hFF);
    emit_case();
    pat_q = {8'h00, 8'hFF};
    txt_q = {8'h00, 8'hFF};
    emit_case();

    while (beats_sent < ITEM_TARGET) begin
      pat_q.delete();
      txt_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // text derived from the pattern, so that many cases match
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        repeat (n) pat_add(pattern_char());
        foreach (pat_q[i]) begin
          c = pat_q[i];
          if (c == CH_STAR) begin
            repeat ($urandom_range(0, 3)) txt_add(text_char());
          end else if (c == CH_ANY) begin
            txt_add(text_char());
          end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
            txt_add($urandom_range(0, 1) ? c ^ 8'h20 : c);
          end else begin
            txt_add(c);
          end
        end
        if ($urandom_range(0, 4) == 0 && txt_q.size() > 0)
          txt_q[$urandom_range(0, txt_q.size() - 1)] = text_char();
        if ($urandom_range(0, 9) == 0) txt_add(text_char());
        while (txt_q.size() > MAX_LEN_DEF) void'(txt_q.pop_back());
      end else if (kind < 85) begin
        repeat ($urandom_range(0, 10)) pat_add(pattern_char());
        repeat ($urandom_range(0, 10)) txt_add(text_char());
      end else if (kind < 92) begin
        repeat ($urandom_range(0, 8)) pat_add(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 8)) txt_add(8'($urandom_range(0, 255)));
      end else if (kind < 97) begin
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(MAX_LEN_DEF + 1, MAX_LEN_DEF + 4)) pat_add(pattern_char());
          repeat ($urandom_range(0, 5)) txt_add(text_char());
        end else begin
          repeat ($urandom_range(0, 5)) pat_add(pattern_char());
          repeat ($urandom_range(MAX_LEN_DEF + 1, MAX_LEN_DEF + 4)) txt_add(text_char());
        end
      end else begin
        // both stores full, long backtracking walk
        for (int i = 0; i < MAX_LEN_DEF; i++) begin
          pat_add((i % 2 == 0) ? CH_STAR : 8'h61);
          txt_add($urandom_range(0, 1) ? 8'h61 : 8'h41);
        end
        pat_q[MAX_LEN_DEF - 1] = 8'h62;
        if ($urandom_range(0, 1)) txt_q[MAX_LEN_DEF - 1] = 8'h42;
      end
      emit_case();
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("%0d command beats sent, %0d evaluates checked", beats_sent, eval_count);
    $display("%0d evaluates matched, %0d reported overflow", match_count, ovf_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
